[hdl/ngh_pkg.sv]
// Shared constants for the noise gate with hold: field widths, reset values,
// fixed-point scales and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package ngh_pkg;

  // default widths of the sample and hold counter
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int HOLD_BITS_DEF   = 20;

  // register and state widths
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int THR_BITS       = 24;
  localparam int COEFF_BITS     = 24;
  localparam int GAIN_BITS      = 24;
  localparam int HOLD_LEN_BITS  = 20;
  localparam int ENV_BITS       = 32;

  // fixed-point scales: coefficients Q0.24, gain Q1.23
  localparam int COEFF_FRAC = 24;
  localparam int GAIN_FRAC  = 23;

  // register reset values
  localparam logic [THR_BITS-1:0]      THR_RESET     = 24'd262144;
  localparam logic [COEFF_BITS-1:0]    ATTACK_RESET  = 24'd16000000;
  localparam logic [COEFF_BITS-1:0]    RELEASE_RESET = 24'd16700000;
  localparam logic [GAIN_BITS-1:0]     FLOOR_RESET   = 24'd0;
  localparam logic [HOLD_LEN_BITS-1:0] HOLD_RESET    = 20'd2400;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_ATTACK    = 3'd1,
    REG_RELEASE   = 3'd2,
    REG_FLOOR     = 3'd3,
    REG_HOLD      = 3'd4
  } cfg_reg_t;

endpackage

[hdl/noise_gate_with_hold_unit.sv]
// Noise gate with hold and envelope follower, one sample per request.
// A request passes through two registers: the input register, then the result register.
// Throughput: one request per cycle while results are taken; the envelope update is a single
// 25 x 33 bit multiply between the input register and the result register.
// Reset (synchronous, active high): gate closed, envelope and hold count zero,
// registers at their defaults, both pipeline stages empty.
// Depends on ngh_pkg.
`timescale 1ns / 1ps

module noise_gate_with_hold_unit
  import ngh_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int HOLD_BITS   = HOLD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  // request channel
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          block_start,
  // result channel
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          gate_is_open
);

  localparam int SHIFT     = ENV_BITS - SAMPLE_BITS;
  localparam int CMP_BITS  = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam int HALF_BITS = THR_BITS + ENV_BITS;
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
  localparam int Q_BITS    = PROD_BITS - GAIN_FRAC;
  localparam int DIFF_BITS = ENV_BITS + 1;
  localparam int MUL_BITS  = COEFF_BITS + 1 + DIFF_BITS;
  localparam int SUM_BITS  = MUL_BITS - COEFF_FRAC;

  localparam logic [Q_BITS-1:0] POS_LIMIT = {2'b00, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [Q_BITS-1:0] NEG_LIMIT = {2'b01, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [PROD_BITS-1:0] ROUND_UP = PROD_BITS'((64'd1 << GAIN_FRAC) - 64'd1);

  // configuration registers
  logic [THR_BITS-1:0]      threshold_level;
  logic [COEFF_BITS-1:0]    attack_coeff;
  logic [COEFF_BITS-1:0]    release_coeff;
  logic [GAIN_BITS-1:0]     floor_gain;
  logic [HOLD_LEN_BITS-1:0] hold_length;

  // gate state
  logic [ENV_BITS-1:0]  envelope;
  logic [HOLD_BITS-1:0] hold_count;
  logic                 open_flag;
  logic [ENV_BITS-1:0]  envelope_next;
  logic [HOLD_BITS-1:0] hold_count_next;
  logic                 open_flag_next;

  // input stage
  logic                   stage_valid;
  logic [SAMPLE_BITS-1:0] stage_sample;
  logic                   stage_start;
  logic                   advance;

  // per-sample datapath
  logic                   is_neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [ENV_BITS-1:0]    mag_env;
  logic [HALF_BITS-1:0]   half_thr;
  logic                   loud;
  logic [ENV_BITS-1:0]    env_cur;
  logic [HOLD_BITS-1:0]   hold_cur;
  logic                   open_cur;
  logic [COEFF_BITS-1:0]  coeff;
  logic signed [DIFF_BITS-1:0] env_diff;
  logic signed [MUL_BITS-1:0]  env_prod;
  logic signed [SUM_BITS-1:0]  env_sum;
  logic [ENV_BITS-1:0]    env_smooth;
  logic [PROD_BITS-1:0]   gain_prod;
  logic [PROD_BITS-1:0]   gain_adj;
  logic [Q_BITS-1:0]      gain_q;
  logic [SAMPLE_BITS-1:0] scaled;
  logic [SAMPLE_BITS-1:0] gated;

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= THR_RESET;
      attack_coeff    <= ATTACK_RESET;
      release_coeff   <= RELEASE_RESET;
      floor_gain      <= FLOOR_RESET;
      hold_length     <= HOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: threshold_level <= cfg_data[THR_BITS-1:0];
        REG_ATTACK:    attack_coeff    <= cfg_data[COEFF_BITS-1:0];
        REG_RELEASE:   release_coeff   <= cfg_data[COEFF_BITS-1:0];
        REG_FLOOR:     floor_gain      <= cfg_data[GAIN_BITS-1:0];
        REG_HOLD:      hold_length     <= cfg_data[HOLD_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the input stage moves on when the result register is free
  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_sample <= sample_in;
      stage_start  <= block_start;
    end
  end

  // magnitude, aligned magnitude and half threshold
  assign is_neg   = stage_sample[SAMPLE_BITS-1];
  assign mag      = is_neg ? (~stage_sample + 1'b1) : stage_sample;
  assign mag_env  = ENV_BITS'(mag) << SHIFT;
  assign half_thr = (HALF_BITS'(threshold_level) << SHIFT) >> 1;
  assign loud     = CMP_BITS'(mag) > CMP_BITS'(threshold_level);

  // state as seen by this sample, cleared at block start
  assign env_cur  = stage_start ? '0 : envelope;
  assign hold_cur = stage_start ? '0 : hold_count;
  assign open_cur = stage_start ? 1'b0 : open_flag;

  // envelope smoothing: mag + floor(c * (env - mag) / 2^24)
  assign coeff      = loud ? attack_coeff : release_coeff;
  assign env_diff   = $signed({1'b0, env_cur}) - $signed({1'b0, mag_env});
  assign env_prod   = $signed({1'b0, coeff}) * env_diff;
  assign env_sum    = $signed({2'b00, mag_env}) + env_prod[MUL_BITS-1:COEFF_FRAC];
  assign env_smooth = env_sum[ENV_BITS-1:0];

  // gate and hold update
  always_comb begin
    envelope_next   = env_cur;
    hold_count_next = hold_cur;
    open_flag_next  = open_cur;
    if (loud) begin
      open_flag_next  = 1'b1;
      hold_count_next = HOLD_BITS'(hold_length);
      envelope_next   = env_smooth;
    end else if (hold_cur != '0) begin
      hold_count_next = hold_cur - 1'b1;
    end else begin
      envelope_next = env_smooth;
      if (HALF_BITS'(env_smooth) < half_thr) begin
        open_flag_next = 1'b0;
      end
    end
  end

  // floor gain scaling, floor division by 2^23, saturated
  assign gain_prod = PROD_BITS'(mag) * PROD_BITS'(floor_gain);
  assign gain_adj  = gain_prod + (is_neg ? ROUND_UP : '0);
  assign gain_q    = gain_adj[PROD_BITS-1:GAIN_FRAC];

  always_comb begin
    if (is_neg) begin
      if (gain_q > NEG_LIMIT) begin
        scaled = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
        scaled = ~gain_q[SAMPLE_BITS-1:0] + 1'b1;
      end
    end else begin
      if (gain_q > POS_LIMIT) begin
        scaled = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
        scaled = gain_q[SAMPLE_BITS-1:0];
      end
    end
  end

  assign gated = open_flag_next ? stage_sample : scaled;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      envelope   <= '0;
      hold_count <= '0;
      open_flag  <= 1'b0;
    end else if (advance) begin
      envelope   <= envelope_next;
      hold_count <= hold_count_next;
      open_flag  <= open_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out   <= gated;
      gate_is_open <= open_flag_next;
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for noise_gate_with_hold_unit: a directed table and then
// random phases of gated audio requests, each result checked against a predictor.
// Depends on ngh_pkg and the unit under test.
`timescale 1ns / 1ps

module tb_top;
  import ngh_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int unsigned FULL_SCALE = 32'd1 << (SB - 1);
  localparam logic [CFG_INDEX_BITS-1:0] IDX_PAST_END = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] IDX_TOP      = 3'd7;

  typedef struct packed {
    logic signed [SB-1:0] smp;
    logic                 is_open;
  } gate_res_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  val;
    logic signed [SB-1:0]      smp;
    logic                      blk;
    bit                        typed;
    gate_res_t                 want;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [CFG_INDEX_BITS-1:0]     cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_data;
  logic                          item_valid;
  logic                          item_ready;
  logic signed [SB-1:0]          sample_in;
  logic                          block_start;
  logic                          result_valid;
  logic                          result_ready;
  logic signed [SB-1:0]          sample_out;
  logic                          gate_is_open;

  // predictor copy of the registers and of the gate state
  logic [THR_BITS-1:0]      thr_q;
  logic [COEFF_BITS-1:0]    atk_q;
  logic [COEFF_BITS-1:0]    rel_q;
  logic [GAIN_BITS-1:0]     flr_q;
  logic [HOLD_LEN_BITS-1:0] hold_len_q;
  logic [ENV_BITS-1:0]      env_q;
  logic [HOLD_LEN_BITS-1:0] hold_cnt_q;
  logic                     open_q;

  gate_res_t gate_expect_q[$];
  dir_row_t  dir_rows[$];
  int        fail_count;
  int        results_seen;
  bit        tx_steady;

  noise_gate_with_hold_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .sample_in    (sample_in),
    .block_start  (block_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample_out   (sample_out),
    .gate_is_open (gate_is_open)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one-pole envelope step, coefficient in Q0.24
  function automatic logic [ENV_BITS-1:0] env_follow(logic [COEFF_BITS-1:0] c,
                                                     logic [ENV_BITS-1:0] env,
                                                     logic [ENV_BITS-1:0] mag32);
    logic [63:0] acc;
    acc = 64'(c) * 64'(env) + (64'd16777216 - 64'(c)) * 64'(mag32);
    return acc[55:24];
  endfunction

  // closed-gate gain: floor division by 2^23, then clamp to the sample range
  function automatic logic signed [SB-1:0] floor_scale(logic signed [SB-1:0] s,
                                                      logic [GAIN_BITS-1:0] g);
    longint mag_l, prod, q;
    mag_l = s[SB-1] ? -longint'(s) : longint'(s);
    prod  = mag_l * longint'(g);
    if (s[SB-1]) q = -((prod + (64'sd1 <<< GAIN_FRAC) - 1) >>> GAIN_FRAC);
    else q = prod >>> GAIN_FRAC;
    if (q > longint'(FULL_SCALE) - 1) q = longint'(FULL_SCALE) - 1;
    if (q < -longint'(FULL_SCALE)) q = -longint'(FULL_SCALE);
    return SB'(q);
  endfunction

  // predicted gated sample for one request, advancing the predictor state
  function automatic gate_res_t gate_predict(logic signed [SB-1:0] s, logic blk);
    logic [SB-1:0]       mag;
    logic [ENV_BITS-1:0] mag32;
    logic [ENV_BITS-1:0] half_thr;
    gate_res_t           r;
    if (blk) begin
      env_q      = '0;
      hold_cnt_q = '0;
      open_q     = 1'b0;
    end
    mag      = s[SB-1] ? -s : s;
    mag32    = {mag, 8'd0};
    half_thr = {thr_q, 8'd0} >> 1;
    if (mag > thr_q) begin
      open_q     = 1'b1;
      hold_cnt_q = hold_len_q;
      env_q      = env_follow(atk_q, env_q, mag32);
    end else if (hold_cnt_q != '0) begin
      hold_cnt_q = hold_cnt_q - 1'b1;
    end else begin
      env_q = env_follow(rel_q, env_q, mag32);
      if (env_q < half_thr) open_q = 1'b0;
    end
    r.smp     = open_q ? s : floor_scale(s, flr_q);
    r.is_open = open_q;
    return r;
  endfunction

  function automatic void gate_cfg_apply(logic [CFG_INDEX_BITS-1:0] idx,
                                         logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_THRESHOLD: thr_q = val;
      REG_ATTACK:    atk_q = val;
      REG_RELEASE:   rel_q = val;
      REG_FLOOR:     flr_q = val;
      REG_HOLD:      hold_len_q = val[HOLD_LEN_BITS-1:0];
      default: ;
    endcase
  endfunction

  // directed table builders
  function automatic void row_cfg(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] val);
    dir_row_t r;
    r = '{kind: ROW_CFG, idx: idx, val: val, smp: '0, blk: 1'b0, typed: 1'b0, want: '0};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void row_item(logic signed [SB-1:0] s, logic blk);
    dir_row_t r;
    r = '{kind: ROW_ITEM, idx: '0, val: '0, smp: s, blk: blk, typed: 1'b0, want: '0};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void row_item_x(logic signed [SB-1:0] s, logic blk,
                                     logic signed [SB-1:0] xs, logic xo);
    dir_row_t r;
    r = '{kind: ROW_ITEM, idx: '0, val: '0, smp: s, blk: blk, typed: 1'b1,
          want: '{smp: xs, is_open: xo}};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random sample above or at/below the current threshold
  function automatic logic signed [SB-1:0] pick_sample(bit loud);
    int unsigned          m;
    logic signed [SB-1:0] v;
    if (loud && thr_q < FULL_SCALE) m = $urandom_range(int'(thr_q) + 1, FULL_SCALE);
    else m = $urandom_range(0, (thr_q > FULL_SCALE) ? FULL_SCALE : int'(thr_q));
    if (m == FULL_SCALE) return {1'b1, {(SB-1){1'b0}}};
    v = SB'(m);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // one configuration write, leaves cfg_write high for the caller to drop
  task automatic cfg_put(input logic [CFG_INDEX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    gate_cfg_apply(idx, val);
  endtask

  // stop requesting until every result is back and the pipeline has emptied
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (gate_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // offer one request and record its expected result once accepted
  task automatic send_item(input logic signed [SB-1:0] s, input logic blk,
                           input bit typed, input gate_res_t want);
    int gap;
    gap = (tx_steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    sample_in   <= s;
    block_start <= blk;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (typed) begin
      void'(gate_predict(s, blk));
      gate_expect_q.insert(gate_expect_q.size(), want);
    end else begin
      gate_expect_q.insert(gate_expect_q.size(), gate_predict(s, blk));
    end
  endtask

  // fresh random settings for one phase; the floor gain sometimes goes
  // above unity to reach saturation
  task automatic shuffle_settings();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) cfg_put(REG_THRESHOLD, CFG_DATA_BITS'($urandom_range(1000, 2000000)));
    else if (pick < 85) cfg_put(REG_THRESHOLD, CFG_DATA_BITS'($urandom_range(0, FULL_SCALE)));
    else cfg_put(REG_THRESHOLD, CFG_DATA_BITS'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 30)
      cfg_put(REG_ATTACK, CFG_DATA_BITS'($urandom_range(15000000, 16777215)));
    else cfg_put(REG_ATTACK, CFG_DATA_BITS'($urandom));
    if ($urandom_range(0, 99) < 30)
      cfg_put(REG_RELEASE, CFG_DATA_BITS'($urandom_range(16000000, 16777215)));
    else cfg_put(REG_RELEASE, CFG_DATA_BITS'($urandom));
    if ($urandom_range(0, 99) < 70)
      cfg_put(REG_FLOOR, CFG_DATA_BITS'($urandom_range(0, FULL_SCALE)));
    else cfg_put(REG_FLOOR, CFG_DATA_BITS'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 60) cfg_put(REG_HOLD, CFG_DATA_BITS'($urandom_range(0, 16)));
    else if (pick < 90) cfg_put(REG_HOLD, CFG_DATA_BITS'($urandom_range(0, 200)));
    else cfg_put(REG_HOLD, CFG_DATA_BITS'($urandom));
    if ($urandom_range(0, 99) < 25)
      cfg_put(CFG_INDEX_BITS'($urandom_range(IDX_PAST_END, IDX_TOP)),
              CFG_DATA_BITS'($urandom));
    cfg_write <= 1'b0;
  endtask

  // compare one accepted result with the oldest expectation
  task automatic take_result();
    gate_res_t e;
    results_seen++;
    if (gate_expect_q.size() == 0) begin
      $display("%0t: unexpected result: sample_out %0d gate_is_open %0b",
               $time, sample_out, gate_is_open);
      fail_count++;
    end else begin
      e = gate_expect_q.pop_front();
      if (sample_out !== e.smp) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, e.smp, sample_out);
        fail_count++;
      end
      if (gate_is_open !== e.is_open) begin
        $display("%0t: gate_is_open expected %0b actual %0b", $time, e.is_open,
                 gate_is_open);
        fail_count++;
      end
    end
  endtask

  // result side: random back-pressure, one long hold-off, steady stretches
  initial begin : result_side
    int  hold_off;
    int  stall;
    bit  long_done;
    bit  rx_steady;
    hold_off  = 0;
    stall     = 0;
    long_done = 1'b0;
    rx_steady = 1'b0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) take_result();
      if (!long_done && results_seen >= 50) begin
        long_done = 1'b1;
        hold_off  = 300;
      end
      if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
      if (hold_off > 0) begin
        hold_off--;
        result_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        result_ready <= 1'b0;
      end else if (rx_steady) begin
        result_ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 99) < 5) stall = idle_len();
        result_ready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    int       n;
    int       loud_n;
    int       quiet_n;
    int       kind;
    bit       cfg_open;
    gate_res_t no_want;
    no_want      = '0;
    fail_count   = 0;
    results_seen = 0;
    tx_steady    = 1'b0;
    cfg_open     = 1'b0;
    thr_q        = THR_RESET;
    atk_q        = ATTACK_RESET;
    rel_q        = RELEASE_RESET;
    flr_q        = FLOOR_RESET;
    hold_len_q   = HOLD_RESET;
    env_q        = '0;
    hold_cnt_q   = '0;
    open_q       = 1'b0;
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    item_valid  <= 1'b0;
    sample_in   <= '0;
    block_start <= 1'b0;

    // defaults after reset: silence, extremes, threshold edge, block restart
    row_item_x(0, 1, 0, 0);
    row_item_x(1000, 0, 0, 0);
    row_item_x(-1000, 0, 0, 0);
    row_item_x(8388607, 0, 8388607, 1);
    row_item_x(-8388608, 0, -8388608, 1);
    row_item_x(262144, 0, 262144, 1);
    row_item_x(262145, 0, 262145, 1);
    row_item_x(-262144, 0, -262144, 1);
    row_item_x(5, 1, 0, 0);
    row_item_x(-8388608, 1, -8388608, 1);
    // unity floor with no hold: closed gate passes the sample through
    row_cfg(REG_FLOOR, 24'd8388608);
    row_cfg(REG_HOLD, 24'd0);
    row_item_x(-3, 1, -3, 0);
    row_item_x(100, 0, 100, 0);
    // floor above unity saturates, top threshold is never exceeded
    row_cfg(REG_FLOOR, 24'hFFFFFF);
    row_cfg(REG_THRESHOLD, 24'd8388608);
    row_item_x(8388607, 1, 8388607, 0);
    row_item_x(-8388608, 0, -8388608, 0);
    row_item(1, 0);
    row_item(-1, 0);
    // zero threshold, extreme coefficients, longest hold, writes past the list
    row_cfg(REG_THRESHOLD, 24'd0);
    row_cfg(REG_ATTACK, 24'd0);
    row_cfg(REG_RELEASE, 24'hFFFFFF);
    row_cfg(REG_HOLD, 24'd1048575);
    row_cfg(REG_FLOOR, 24'h123456);
    row_cfg(IDX_PAST_END, 24'hABCDEF);
    row_cfg(IDX_TOP, 24'h000001);
    row_item_x(0, 1, 0, 0);
    row_item_x(1, 0, 1, 1);
    row_item_x(0, 0, 0, 1);
    row_item_x(-5, 0, -5, 1);
    // one-sample hold, then instant release
    row_cfg(REG_HOLD, 24'd1);
    row_cfg(REG_ATTACK, 24'hFFFFFF);
    row_cfg(REG_RELEASE, 24'd0);
    row_cfg(REG_THRESHOLD, 24'd1000);
    row_item_x(5000, 1, 5000, 1);
    row_item_x(0, 0, 0, 1);
    row_item(0, 0);
    row_item(999, 0);
    row_item(-999, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!cfg_open) wait_drained();
        cfg_open = 1'b1;
        cfg_put(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        if (cfg_open) cfg_write <= 1'b0;
        cfg_open = 1'b0;
        send_item(dir_rows[i].smp, dir_rows[i].blk, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases: loud bursts with quiet tails, plus some noise
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      shuffle_settings();
      tx_steady = (ph % 3 == 2);
      n = 0;
      while (n < 40) begin
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
          send_item(SB'($urandom), $urandom_range(0, 99) < 5, 1'b0, no_want);
          n++;
        end else begin
          loud_n  = $urandom_range(1, 6);
          quiet_n = $urandom_range(2, 30);
          for (int k = 0; k < loud_n; k++)
            send_item(pick_sample(1'b1), (k == 0) && ($urandom_range(0, 99) < 10),
                      1'b0, no_want);
          for (int k = 0; k < quiet_n; k++)
            send_item(pick_sample(1'b0), 1'b0, 1'b0, no_want);
          n += loud_n + quiet_n;
        end
      end
    end
    tx_steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
